/* rtl/core/qsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types, character codes and helpers for the quoted string unescaper.
// ----------------------------------------------------------------------------
package qsu_pkg;

    // character codes
    localparam logic [7:0] QUOTE_CH  = 8'h22;
    localparam logic [7:0] BSLASH_CH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] LF_CH     = 8'h0A;
    localparam logic [7:0] CR_CH     = 8'h0D;
    localparam logic [7:0] TAB_CH    = 8'h09;

    // decoder phase
    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_OCT2 = 3'd5,
        PH_OCT3 = 3'd6
    } phase_t;

    // input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
        logic       failed;
    } out_item_t;

    // decoder state
    typedef struct packed {
        phase_t     phase;
        logic [7:0] acc;
        logic       err;
    } dec_state_t;

    // one decode step: next state and optional result
    typedef struct packed {
        dec_state_t state_next;
        logic       emit;
        out_item_t  result;
    } dec_step_t;

    // hex digit decode: bit 4 set when the byte is a valid hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            r = {1'b1, 4'(b[2:0] + 3'd1) + 4'd8};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/qsu_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_decoder
// Combinational escape decoder: from the current state and one raw byte,
// forms the next state and at most one result transaction.
// ----------------------------------------------------------------------------
module qsu_decoder (
    input  wire qsu_pkg::dec_state_t state,
    input  wire qsu_pkg::in_item_t   item,
    output qsu_pkg::dec_step_t       step
);

    logic [7:0] b;
    logic [4:0] hv;
    logic       is_oct;

    assign b      = item.in_byte;
    assign hv     = qsu_pkg::hex_decode(b);
    assign is_oct = (b >= qsu_pkg::CH_0) && (b <= qsu_pkg::CH_7);

    // next state and result
    always_comb
    begin
        step.state_next = state;
        step.emit       = 1'b0;
        step.result     = '0;

        if (item.in_last)
        begin
            // status transaction, and back to reset state
            step.emit                 = 1'b1;
            step.result.end_of_string = 1'b1;
            step.result.failed        = state.err || (state.phase != qsu_pkg::PH_BODY) ||
                                        (b != qsu_pkg::QUOTE_CH);
            step.state_next.phase     = qsu_pkg::PH_OPEN;
            step.state_next.acc       = 8'd0;
            step.state_next.err       = 1'b0;
        end
        else if (!state.err)
        begin
            case (state.phase)
                qsu_pkg::PH_OPEN:
                begin
                    if (b == qsu_pkg::QUOTE_CH)
                        step.state_next.phase = qsu_pkg::PH_BODY;
                    else
                        step.state_next.err = 1'b1;
                end
                qsu_pkg::PH_BODY:
                begin
                    if (b == qsu_pkg::BSLASH_CH)
                        step.state_next.phase = qsu_pkg::PH_ESC;
                    else if (b == qsu_pkg::QUOTE_CH)
                        step.state_next.err = 1'b1;
                    else
                    begin
                        step.emit            = 1'b1;
                        step.result.out_byte = b;
                    end
                end
                qsu_pkg::PH_ESC:
                begin
                    case (b) inside
                        qsu_pkg::CH_N:
                        begin
                            step.state_next.phase = qsu_pkg::PH_BODY;
                            step.emit             = 1'b1;
                            step.result.out_byte  = qsu_pkg::LF_CH;
                        end
                        qsu_pkg::CH_R:
                        begin
                            step.state_next.phase = qsu_pkg::PH_BODY;
                            step.emit             = 1'b1;
                            step.result.out_byte  = qsu_pkg::CR_CH;
                        end
                        qsu_pkg::CH_T:
                        begin
                            step.state_next.phase = qsu_pkg::PH_BODY;
                            step.emit             = 1'b1;
                            step.result.out_byte  = qsu_pkg::TAB_CH;
                        end
                        qsu_pkg::CH_X:
                            step.state_next.phase = qsu_pkg::PH_HEX1;
                        [qsu_pkg::CH_0 : qsu_pkg::CH_3]:
                        begin
                            step.state_next.acc   = {6'd0, b[1:0]};
                            step.state_next.phase = qsu_pkg::PH_OCT2;
                        end
                        [8'h34 : qsu_pkg::CH_9]:
                            step.state_next.err = 1'b1;
                        default:
                        begin
                            step.state_next.phase = qsu_pkg::PH_BODY;
                            step.emit             = 1'b1;
                            step.result.out_byte  = b;
                        end
                    endcase
                end
                qsu_pkg::PH_HEX1:
                begin
                    if (!hv[4])
                        step.state_next.err = 1'b1;
                    else
                    begin
                        step.state_next.acc   = {4'd0, hv[3:0]};
                        step.state_next.phase = qsu_pkg::PH_HEX2;
                    end
                end
                qsu_pkg::PH_HEX2:
                begin
                    if (!hv[4])
                        step.state_next.err = 1'b1;
                    else
                    begin
                        step.state_next.phase = qsu_pkg::PH_BODY;
                        step.emit             = 1'b1;
                        step.result.out_byte  = {state.acc[3:0], hv[3:0]};
                    end
                end
                qsu_pkg::PH_OCT2:
                begin
                    if (!is_oct)
                        step.state_next.err = 1'b1;
                    else
                    begin
                        step.state_next.acc   = {state.acc[4:0], b[2:0]};
                        step.state_next.phase = qsu_pkg::PH_OCT3;
                    end
                end
                qsu_pkg::PH_OCT3:
                begin
                    if (!is_oct)
                        step.state_next.err = 1'b1;
                    else
                    begin
                        step.state_next.phase = qsu_pkg::PH_BODY;
                        step.emit             = 1'b1;
                        step.result.out_byte  = {state.acc[4:0], b[2:0]};
                    end
                end
                default:
                    step.state_next.err = 1'b1;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/quoted_string_unescaper_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_string_unescaper_core
// Decodes a double-quoted string with C-style escapes, one raw byte per
// transaction, and reports a pass/fail status on the final byte.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_data  (byte, last flag)
//   out     | output    | out_valid / out_ready| out_data (byte, end, failed)
//
// One raw byte per clock cycle sustained while out is not stalled; a result passes
// through the input register, then the result register.
// The decode state updates as a byte leaves the input register, so each
// byte sees the state left by the one before it with no bubble.
// Reset (rst_n low) empties both registers and returns to expecting the
// opening quote. A stall on out holds the result register; the input
// register still takes a byte while it is empty.
// ----------------------------------------------------------------------------
module quoted_string_unescaper_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire qsu_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output qsu_pkg::out_item_t  out_data
);

    logic                 in_valid_reg;
    qsu_pkg::in_item_t    in_item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    qsu_pkg::out_item_t   out_item_reg;
    qsu_pkg::dec_state_t  state_reg;
    qsu_pkg::dec_step_t   step;
    logic                 advance;

    // a buffered byte moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
    end

    // escape decode
    qsu_decoder u_decoder (
        .state (state_reg),
        .item  (in_item_reg),
        .step  (step)
    );

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= qsu_pkg::PH_OPEN;
            state_reg.acc   <= 8'd0;
            state_reg.err   <= 1'b0;
        end
        else if (advance)
            state_reg <= step.state_next;
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (advance && step.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.emit)
            out_item_reg <= step.result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

`ifndef SYNTHESIS
    // a final byte leaves the decoder in its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.in_last) |=>
            (state_reg.phase == qsu_pkg::PH_OPEN && state_reg.acc == 8'd0 && !state_reg.err))
        else $error("state not cleared after final byte");

    // no decoded byte once an error is latched
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.err && !in_item_reg.in_last) |-> !step.emit)
        else $error("decoded byte emitted after error");

    // decoded bytes never carry status flags; status carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.end_of_string) |-> !out_item_reg.failed)
        else $error("failed flag on a decoded byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.end_of_string) |-> (out_item_reg.out_byte == 8'd0))
        else $error("non-zero byte on status transaction");
`endif

endmodule
`default_nettype wire

/* sim/quoted_string_unescaper_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescaper_core_test
// Self-checking bench for the quoted string unescaper. A short table of
// directed strings comes first: missing and swallowed quotes, byte extremes
// and three escape forms. Random strings follow, mostly well formed, some
// broken and some pure noise. Every accepted input transaction goes through
// an in-bench decoder model, and each output transaction is compared with
// the oldest expected result. Both sides idle at varying rates.
// ----------------------------------------------------------------------------
module quoted_string_unescaper_core_test;
    import qsu_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int IDLE_PHASES   = 3;
    localparam int DIRECTED_ROWS = 24;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;

    // expectation attached to a stimulus row; typed = 0 leaves it to the model
    typedef struct packed {
        logic      typed;
        logic      emit;
        out_item_t res;
    } row_check_t;

    typedef struct packed {
        in_item_t   stim;
        row_check_t chk;
    } dir_row_t;

    // random string shapes
    typedef enum int {
        BRK_OVERWRITE,
        BRK_TRUNCATE,
        BRK_NO_OPEN,
        BRK_INSERT,
        BRK_SLOPPY
    } break_mode_t;

    typedef enum int {
        EL_PLAIN,
        EL_CTRL,
        EL_HEX,
        EL_OCT,
        EL_LITERAL,
        EL_SLOPPY_HEX,
        EL_SLOPPY_OCT
    } element_t;

    localparam row_check_t BY_MODEL = '0;
    localparam row_check_t EXP_NONE = {1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam row_check_t EXP_PASS = {1'b1, 1'b1, 8'h00, 1'b1, 1'b0};
    localparam row_check_t EXP_FAIL = {1'b1, 1'b1, 8'h00, 1'b1, 1'b1};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int error_count   = 0;

    // decoder model state
    phase_t     dec_phase = PH_OPEN;
    logic [7:0] dec_acc   = '0;
    logic       dec_err   = 1'b0;

    dir_row_t   directed_rows [0:DIRECTED_ROWS-1];
    row_check_t row_checks [$];
    out_item_t  pending_results [$];
    in_item_t   raw_bytes [$];

    quoted_string_unescaper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic row_check_t exp_byte(input logic [7:0] b);
        return {1'b1, 1'b1, b, 1'b0, 1'b0};
    endfunction

    // hex digit: bit 4 set when valid, low nibble the value
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= CH_0 && b <= CH_9)
        begin
            d = b - CH_0;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // one raw byte through the decoder model; returns 1 when a result is due
    function automatic logic decode_byte(input in_item_t it, output out_item_t res);
        logic [7:0] b;
        logic [4:0] hv;
        logic       emit;
        b    = it.in_byte;
        res  = '0;
        emit = 1'b0;
        hv   = hex_nibble(b);
        if (it.in_last)
        begin
            res.end_of_string = 1'b1;
            res.failed        = dec_err || dec_phase != PH_BODY || b != QUOTE_CH;
            dec_phase = PH_OPEN;
            dec_acc   = '0;
            dec_err   = 1'b0;
            return 1'b1;
        end
        if (dec_err)
            return 1'b0;
        case (dec_phase)
            PH_OPEN:
            begin
                if (b == QUOTE_CH)
                    dec_phase = PH_BODY;
                else
                    dec_err = 1'b1;
            end
            PH_BODY:
            begin
                if (b == BSLASH_CH)
                    dec_phase = PH_ESC;
                else if (b == QUOTE_CH)
                    dec_err = 1'b1;
                else
                begin
                    res.out_byte = b;
                    emit = 1'b1;
                end
            end
            PH_ESC:
            begin
                dec_phase = PH_BODY;
                if (b == CH_N)
                begin
                    res.out_byte = LF_CH;
                    emit = 1'b1;
                end
                else if (b == CH_R)
                begin
                    res.out_byte = CR_CH;
                    emit = 1'b1;
                end
                else if (b == CH_T)
                begin
                    res.out_byte = TAB_CH;
                    emit = 1'b1;
                end
                else if (b == CH_X)
                    dec_phase = PH_HEX1;
                else if (b >= CH_0 && b <= CH_9)
                begin
                    // first octal digit above 3 would overflow a byte
                    if (b <= CH_3)
                    begin
                        dec_acc   = b - CH_0;
                        dec_phase = PH_OCT2;
                    end
                    else
                        dec_err = 1'b1;
                end
                else
                begin
                    res.out_byte = b;
                    emit = 1'b1;
                end
            end
            PH_HEX1:
            begin
                if (!hv[4])
                    dec_err = 1'b1;
                else
                begin
                    dec_acc   = {4'h0, hv[3:0]};
                    dec_phase = PH_HEX2;
                end
            end
            PH_HEX2:
            begin
                if (!hv[4])
                    dec_err = 1'b1;
                else
                begin
                    res.out_byte = {dec_acc[3:0], hv[3:0]};
                    emit = 1'b1;
                    dec_phase = PH_BODY;
                end
            end
            PH_OCT2:
            begin
                if (b < CH_0 || b > CH_7)
                    dec_err = 1'b1;
                else
                begin
                    dec_acc   = {dec_acc[4:0], b[2:0]};
                    dec_phase = PH_OCT3;
                end
            end
            PH_OCT3:
            begin
                if (b < CH_0 || b > CH_7)
                    dec_err = 1'b1;
                else
                begin
                    res.out_byte = {dec_acc[4:0], b[2:0]};
                    emit = 1'b1;
                    dec_phase = PH_BODY;
                end
            end
            default:
                dec_err = 1'b1;
        endcase
        return emit;
    endfunction

    // random upper or lower case hex character
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_0 + {4'h0, n};
        return (($urandom_range(1) == 0) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic last);
        raw_bytes.push_back({b, last});
    endtask

    // one body element: a plain byte or an escape sequence
    task automatic add_element(input logic sloppy);
        element_t   kind;
        logic [7:0] b;
        logic [7:0] v;
        int         pick;
        pick = $urandom_range(sloppy ? 11 : 9);
        if (pick >= 10)
            kind = (pick == 10) ? EL_SLOPPY_HEX : EL_SLOPPY_OCT;
        else if (pick == 5)
            kind = EL_CTRL;
        else if (pick == 6)
            kind = EL_HEX;
        else if (pick == 7)
            kind = EL_OCT;
        else if (pick == 8)
            kind = EL_LITERAL;
        else
            kind = EL_PLAIN;
        v = 8'($urandom_range(255));
        case (kind)
            EL_PLAIN:
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == QUOTE_CH || b == BSLASH_CH);
                put_byte(b, 1'b0);
            end
            EL_CTRL:
            begin
                put_byte(BSLASH_CH, 1'b0);
                case ($urandom_range(2))
                    0: put_byte(CH_N, 1'b0);
                    1: put_byte(CH_R, 1'b0);
                    default: put_byte(CH_T, 1'b0);
                endcase
            end
            EL_HEX:
            begin
                put_byte(BSLASH_CH, 1'b0);
                put_byte(CH_X, 1'b0);
                put_byte(hex_char(v[7:4]), 1'b0);
                put_byte(hex_char(v[3:0]), 1'b0);
            end
            EL_OCT:
            begin
                put_byte(BSLASH_CH, 1'b0);
                put_byte(CH_0 + {6'd0, v[7:6]}, 1'b0);
                put_byte(CH_0 + {5'd0, v[5:3]}, 1'b0);
                put_byte(CH_0 + {5'd0, v[2:0]}, 1'b0);
            end
            EL_LITERAL:
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_N || b == CH_R || b == CH_T || b == CH_X ||
                       (b >= CH_0 && b <= CH_9));
                put_byte(BSLASH_CH, 1'b0);
                put_byte(b, 1'b0);
            end
            EL_SLOPPY_HEX:
            begin
                put_byte(BSLASH_CH, 1'b0);
                put_byte(CH_X, 1'b0);
                put_byte(8'($urandom_range(8'h7A, 8'h30)), 1'b0);
                put_byte(8'($urandom_range(8'h7A, 8'h30)), 1'b0);
            end
            default:
            begin
                put_byte(BSLASH_CH, 1'b0);
                repeat (3)
                    put_byte(8'($urandom_range(CH_9, CH_0)), 1'b0);
            end
        endcase
    endtask

    // fills raw_bytes with one string: clean, broken or noise
    task automatic build_random_string();
        int          shape;
        int          n;
        int          k;
        logic        broken;
        break_mode_t brk;
        in_item_t    tail;
        raw_bytes.delete();
        shape  = $urandom_range(99);
        broken = (shape >= 78);
        brk    = break_mode_t'($urandom_range(4));
        if (shape >= 95)
        begin
            // noise, with the odd early end flag
            n = $urandom_range(6, 1);
            repeat (n)
                put_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
        else
        begin
            put_byte(QUOTE_CH, 1'b0);
            n = $urandom_range(12);
            repeat (n)
                add_element(broken && brk == BRK_SLOPPY);
            put_byte(QUOTE_CH, 1'b0);
            if (broken)
            begin
                case (brk)
                    BRK_OVERWRITE:
                    begin
                        k = $urandom_range(raw_bytes.size() - 1);
                        raw_bytes[k] = {8'($urandom_range(255)), 1'b0};
                    end
                    BRK_TRUNCATE:
                    begin
                        k = $urandom_range(raw_bytes.size() - 1);
                        while (raw_bytes.size() > k + 1)
                            tail = raw_bytes.pop_back();
                    end
                    BRK_NO_OPEN:
                        tail = raw_bytes.pop_front();
                    BRK_INSERT:
                    begin
                        k = $urandom_range(raw_bytes.size() - 1, 1);
                        raw_bytes.insert(k, {8'($urandom_range(255)), 1'b0});
                    end
                    default:
                        ;
                endcase
            end
        end
        tail = raw_bytes.pop_back();
        tail.in_last = 1'b1;
        raw_bytes.push_back(tail);
    endtask

    // present one input transaction and hold it until accepted
    task automatic send_item(input in_item_t it, input row_check_t chk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        row_checks.push_back(chk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= sink_idle_pct);

    // scoreboard: results checked first, then the new input transaction
    always @(posedge clk)
    begin : scoreboard
        out_item_t  want;
        out_item_t  predicted;
        row_check_t chk;
        logic       emit;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, out_data);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.out_byte, out_data.out_byte);
                        error_count++;
                    end
                    if (out_data.end_of_string !== want.end_of_string)
                    begin
                        $display("%0t: end_of_string expected %b, got %b",
                                 $time, want.end_of_string, out_data.end_of_string);
                        error_count++;
                    end
                    if (out_data.failed !== want.failed)
                    begin
                        $display("%0t: failed expected %b, got %b",
                                 $time, want.failed, out_data.failed);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                chk = (row_checks.size() != 0) ? row_checks.pop_front() : BY_MODEL;
                emit = decode_byte(in_data, predicted);
                // a typed row overrides the model
                if (chk.typed)
                begin
                    emit      = chk.emit;
                    predicted = chk.res;
                end
                if (emit)
                    pending_results.push_back(predicted);
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int items_in_phase;
        int ph;
        directed_rows = '{
            {8'h41,     1'b0, EXP_NONE},        // missing opening quote
            {QUOTE_CH,  1'b1, EXP_FAIL},
            {QUOTE_CH,  1'b0, EXP_NONE},
            {8'h00,     1'b0, exp_byte(8'h00)}, // zero byte passes through
            {8'hFF,     1'b0, exp_byte(8'hFF)},
            {BSLASH_CH, 1'b0, EXP_NONE},
            {CH_N,      1'b0, BY_MODEL},
            {BSLASH_CH, 1'b0, EXP_NONE},
            {CH_X,      1'b0, EXP_NONE},
            {8'h66,     1'b0, EXP_NONE},
            {8'h46,     1'b0, BY_MODEL},
            {BSLASH_CH, 1'b0, EXP_NONE},
            {CH_3,      1'b0, EXP_NONE},
            {CH_7,      1'b0, EXP_NONE},
            {CH_7,      1'b0, BY_MODEL},
            {QUOTE_CH,  1'b1, EXP_PASS},
            {QUOTE_CH,  1'b1, EXP_FAIL},        // string of a single quote
            {QUOTE_CH,  1'b0, EXP_NONE},
            {BSLASH_CH, 1'b0, EXP_NONE},
            {QUOTE_CH,  1'b1, EXP_FAIL},        // closing quote taken by escape
            {QUOTE_CH,  1'b0, EXP_NONE},
            {QUOTE_CH,  1'b0, EXP_NONE},        // unescaped quote inside
            {8'h7A,     1'b0, EXP_NONE},
            {QUOTE_CH,  1'b1, EXP_FAIL}
        };

        // reset
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 26;
        sink_idle_pct <= 64;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(directed_rows[i].stim, directed_rows[i].chk);

        // random strings over the idle phases
        for (ph = 0; ph < IDLE_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct  = 26;
                    sink_idle_pct <= 64;
                end
                1:
                begin
                    src_idle_pct  = 64;
                    sink_idle_pct <= 26;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct <= 0;
                end
            endcase
            items_in_phase = 0;
            while (items_in_phase < RANDOM_ITEMS / IDLE_PHASES)
            begin
                build_random_string();
                items_in_phase += raw_bytes.size();
                for (int i = 0; i < raw_bytes.size(); i++)
                    send_item(raw_bytes[i], BY_MODEL);
            end
        end
        in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0 || row_checks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/qsu_pkg.sv
rtl/core/qsu_decoder.sv
rtl/core/quoted_string_unescaper_core.sv
sim/quoted_string_unescaper_core_test.sv
